// ----- rtl/ptss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_pkg: shared definitions for the periodic task slot scheduler
// Slot table sizing, command and status codes, result record and helpers.
// ----------------------------------------------------------------------------
package ptss_pkg;

	localparam int NUM_SLOTS      = 8;
	localparam int NUM_TASK_KINDS = 4;

	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_PORT_W = 4;
	localparam int TASK_W      = 2;
	localparam int PERIOD_W    = 16;
	localparam int STATUS_W    = 3;
	localparam int MODE_W      = 2;

	localparam logic [SLOT_W-1:0]    LAST_SLOT   = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [SLOT_PORT_W:0] SLOT_LIMIT  = (SLOT_PORT_W + 1)'(NUM_SLOTS);
	localparam logic [TASK_W:0]      TASK_LIMIT  = (TASK_W + 1)'(NUM_TASK_KINDS);
	localparam logic [PERIOD_W-1:0]  ELAPSED_MAX = 16'hFFFF;

	// Power-on table contents
	localparam logic [PERIOD_W-1:0] RESET_PERIOD0 = 16'd500;
	localparam logic [PERIOD_W-1:0] RESET_PERIOD1 = 16'd1000;
	localparam logic [TASK_W-1:0]   RESET_TASK1   = 2'd1;

	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SET    = 2'd3;

	localparam logic KIND_FIRE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UPDATED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_REMOVED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_SET     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_INDEX   = 3'd6;
	localparam logic [STATUS_W-1:0] STAT_UNUSED  = 3'd7;
	localparam logic [STATUS_W-1:0] FIRE_STATUS  = STAT_ADDED;

	typedef struct packed {
		logic                   kind;
		logic [SLOT_PORT_W-1:0] slot;
		logic [TASK_W-1:0]      fired_task;
		logic [STATUS_W-1:0]    status;
		logic                   last;
	} result_t;

	function automatic result_t mk_status(input logic [SLOT_PORT_W-1:0] slot,
			input logic [TASK_W-1:0] tsk, input logic [STATUS_W-1:0] stat);
		result_t r;
		r.kind       = KIND_STATUS;
		r.slot       = slot;
		r.fired_task = tsk;
		r.status     = stat;
		r.last       = 1'b1;
		return r;
	endfunction

	function automatic result_t mk_fire(input logic [SLOT_W-1:0] slot,
			input logic [TASK_W-1:0] tsk, input logic is_last);
		result_t r;
		r.kind       = KIND_FIRE;
		r.slot       = SLOT_PORT_W'(slot);
		r.fired_task = tsk;
		r.status     = FIRE_STATUS;
		r.last       = is_last;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/periodic_task_slot_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Table of periodic task slots with tick, add, remove and set-period commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Remove and set finish
// in the accept cycle: the status result shows on the next cycle and busy stays
// low, so one of them can be issued every cycle. Tick and a valid add walk the
// slot table through a single increment/compare unit, one slot per cycle, then
// pass a closing state, busy high throughout. An add with a zero period or bad
// task id and a tick while paused complete at once; only the add gives a result.
// Fire results of a tick come out during the walk, each held back until the
// next due slot turns up so that the final one can carry last; the final one
// appears after the closing state.
// Every result is shown on the result ports for one cycle with res_strobe high
// and there is no way to hold it off: the receiver must take it then.
// The pause register may be written whenever busy is low.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler import ptss_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [MODE_W-1:0]      mode,
	input  wire logic [TASK_W-1:0]      task_id,
	input  wire logic [SLOT_PORT_W-1:0] slot_index,
	input  wire logic [PERIOD_W-1:0]    period_ticks,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data,
	output logic                        res_strobe,
	output logic                        kind,
	output logic [SLOT_PORT_W-1:0]      slot,
	output logic [TASK_W-1:0]           fired_task,
	output logic [STATUS_W-1:0]         status,
	output logic                        last
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]          state_q;
	logic [SLOT_W-1:0]   scan_q;
	logic                op_add_q;
	logic                paused_q;

	logic                slot_valid_q   [NUM_SLOTS];
	logic [TASK_W-1:0]   slot_task_q    [NUM_SLOTS];
	logic [PERIOD_W-1:0] slot_period_q  [NUM_SLOTS];
	logic [PERIOD_W-1:0] slot_elapsed_q [NUM_SLOTS];

	logic [TASK_W-1:0]   cmd_task_q;
	logic [PERIOD_W-1:0] cmd_period_q;
	logic                match_found_q;
	logic [SLOT_W-1:0]   match_idx_q;
	logic                free_found_q;
	logic [SLOT_W-1:0]   free_idx_q;

	logic                pend_valid_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [TASK_W-1:0]   pend_task_q;

	logic                res_strobe_q;
	result_t             res_q;

	// Shared unit: saturating increment and due compare on the scanned slot
	logic                cur_valid;
	logic [TASK_W-1:0]   cur_task;
	logic [PERIOD_W-1:0] cur_period;
	logic [PERIOD_W-1:0] cur_elapsed;
	logic [PERIOD_W-1:0] elapsed_inc;
	logic                due;
	logic                task_hit;

	// Direct command decode
	logic                idx_ok;
	logic                tid_ok;
	logic [SLOT_W-1:0]   idx_sel;

	assign cur_valid   = slot_valid_q[scan_q];
	assign cur_task    = slot_task_q[scan_q];
	assign cur_period  = slot_period_q[scan_q];
	assign cur_elapsed = slot_elapsed_q[scan_q];
	assign elapsed_inc = (cur_elapsed == ELAPSED_MAX) ? cur_elapsed : cur_elapsed + 16'd1;
	assign due         = elapsed_inc >= cur_period;
	assign task_hit    = cur_task == cmd_task_q;

	assign idx_ok  = {1'b0, slot_index} < SLOT_LIMIT;
	assign tid_ok  = {1'b0, task_id} < TASK_LIMIT;
	assign idx_sel = slot_index[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scan_q        <= '0;
			op_add_q      <= 1'b0;
			paused_q      <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			res_strobe_q  <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_valid_q[i]   <= (i < 2);
				slot_task_q[i]    <= (i == 1) ? RESET_TASK1 : '0;
				slot_period_q[i]  <= (i == 0) ? RESET_PERIOD0 :
				                     (i == 1) ? RESET_PERIOD1 : '0;
				slot_elapsed_q[i] <= '0;
			end
		end else begin
			res_strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				paused_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (mode)
							MODE_TICK: begin
								if (!paused_q) begin
									state_q      <= S_SCAN;
									op_add_q     <= 1'b0;
									scan_q       <= '0;
									pend_valid_q <= 1'b0;
								end
							end
							MODE_ADD: begin
								if (period_ticks == '0) begin
									res_strobe_q <= 1'b1;
									res_q        <= mk_status('0, task_id, STAT_RANGE);
								end else if (!tid_ok) begin
									res_strobe_q <= 1'b1;
									res_q        <= mk_status('0, task_id, STAT_INDEX);
								end else begin
									state_q       <= S_SCAN;
									op_add_q      <= 1'b1;
									scan_q        <= '0;
									cmd_task_q    <= task_id;
									cmd_period_q  <= period_ticks;
									match_found_q <= 1'b0;
									free_found_q  <= 1'b0;
								end
							end
							MODE_REMOVE: begin
								res_strobe_q <= 1'b1;
								if (!idx_ok) begin
									res_q <= mk_status(slot_index, '0, STAT_INDEX);
								end else begin
									// Clear even an empty slot
									res_q <= mk_status(slot_index, slot_task_q[idx_sel],
										STAT_REMOVED);
									slot_valid_q[idx_sel]   <= 1'b0;
									slot_task_q[idx_sel]    <= '0;
									slot_period_q[idx_sel]  <= '0;
									slot_elapsed_q[idx_sel] <= '0;
								end
							end
							default: begin
								res_strobe_q <= 1'b1;
								if (!idx_ok || !slot_valid_q[idx_sel]) begin
									res_q <= mk_status(slot_index, '0, STAT_INDEX);
								end else if (period_ticks == '0) begin
									res_q <= mk_status(slot_index, slot_task_q[idx_sel],
										STAT_RANGE);
								end else begin
									res_q <= mk_status(slot_index, slot_task_q[idx_sel],
										STAT_SET);
									slot_period_q[idx_sel]  <= period_ticks;
									slot_elapsed_q[idx_sel] <= '0;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (op_add_q) begin
						if (cur_valid && task_hit && !match_found_q) begin
							match_found_q <= 1'b1;
							match_idx_q   <= scan_q;
						end
						if (!cur_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= scan_q;
						end
					end else if (cur_valid) begin
						if (due) begin
							slot_elapsed_q[scan_q] <= '0;
							// Release the held fire event; this one may be the final
							if (pend_valid_q) begin
								res_strobe_q <= 1'b1;
								res_q        <= mk_fire(pend_slot_q, pend_task_q, 1'b0);
							end
							pend_valid_q <= 1'b1;
							pend_slot_q  <= scan_q;
							pend_task_q  <= cur_task;
						end else begin
							slot_elapsed_q[scan_q] <= elapsed_inc;
						end
					end
					if (scan_q == LAST_SLOT) begin
						state_q <= S_FINISH;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
					if (op_add_q) begin
						res_strobe_q <= 1'b1;
						if (match_found_q) begin
							slot_period_q[match_idx_q]  <= cmd_period_q;
							slot_elapsed_q[match_idx_q] <= '0;
							res_q <= mk_status(SLOT_PORT_W'(match_idx_q), cmd_task_q,
								STAT_UPDATED);
						end else if (free_found_q) begin
							slot_valid_q[free_idx_q]   <= 1'b1;
							slot_task_q[free_idx_q]    <= cmd_task_q;
							slot_period_q[free_idx_q]  <= cmd_period_q;
							slot_elapsed_q[free_idx_q] <= '0;
							res_q <= mk_status(SLOT_PORT_W'(free_idx_q), cmd_task_q,
								STAT_ADDED);
						end else begin
							res_q <= mk_status('0, cmd_task_q, STAT_FULL);
						end
					end else if (pend_valid_q) begin
						res_strobe_q <= 1'b1;
						res_q        <= mk_fire(pend_slot_q, pend_task_q, 1'b1);
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign cfg_ready  = !busy;
	assign res_strobe = res_strobe_q;
	assign kind       = res_q.kind;
	assign slot       = res_q.slot;
	assign fired_task = res_q.fired_task;
	assign status     = res_q.status;
	assign last       = res_q.last;

endmodule
`default_nettype wire

// ----- rtl/ptss_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_checker
// Port-level checks on the scheduler's command and result behavior.
// ----------------------------------------------------------------------------
module ptss_checker import ptss_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic [MODE_W-1:0]      mode,
	input wire logic                   cfg_ready,
	input wire logic                   res_strobe,
	input wire logic                   kind,
	input wire logic [STATUS_W-1:0]    status,
	input wire logic                   last
);

	// Remove and set give a single final status in the cycle after the accept
	a_direct_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_REMOVE || mode == MODE_SET))
		|=> (res_strobe && kind == KIND_STATUS && last))
		else $error("remove/set transaction gave no status result");

	// Each add, remove or set yields exactly one result, so a status is always final
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && kind == KIND_STATUS) |-> last)
		else $error("status result not marked last");

	a_fire_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && kind == KIND_FIRE) |-> (status == FIRE_STATUS))
		else $error("fire result carries a status code");

	a_no_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> (status != STAT_UNUSED))
		else $error("undefined status code");

	// Pause writes only between commands
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("config accepted while a command runs");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.mode       (mode),
	.cfg_ready  (cfg_ready),
	.res_strobe (res_strobe),
	.kind       (kind),
	.status     (status),
	.last       (last)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for periodic_task_slot_scheduler
// Drives directed and random tick/add/remove/set commands with random gaps,
// toggles the pause register between phases, and checks every fire and
// status result against a tracked copy of the slot table.
// ----------------------------------------------------------------------------
module tb;
	import ptss_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = NUM_SLOTS + 4;

	class slot_table_tracker;
		bit                    paused;
		logic                  valid [NUM_SLOTS];
		logic [TASK_W-1:0]     tasks [NUM_SLOTS];
		logic [PERIOD_W-1:0]   period [NUM_SLOTS];
		logic [PERIOD_W-1:0]   elapsed [NUM_SLOTS];
		result_t               pending_results [$];
		int                    errors;

		function new();
			paused = 1'b0;
			errors = 0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				valid[i] = 1'b0;
				tasks[i] = '0;
				period[i] = '0;
				elapsed[i] = '0;
			end
			valid[0] = 1'b1;
			period[0] = RESET_PERIOD0;
			valid[1] = 1'b1;
			tasks[1] = RESET_TASK1;
			period[1] = RESET_PERIOD1;
		endfunction

		function void post_status(input logic [SLOT_PORT_W-1:0] s,
				input logic [TASK_W-1:0] t, input logic [STATUS_W-1:0] st);
			result_t r;
			r.kind = KIND_STATUS;
			r.slot = s;
			r.fired_task = t;
			r.status = st;
			r.last = 1'b1;
			pending_results.push_back(r);
		endfunction

		// Note one accepted command and queue the results it must produce
		function void take_command(input logic [MODE_W-1:0] m, input logic [TASK_W-1:0] tid,
				input logic [SLOT_PORT_W-1:0] idx, input logic [PERIOD_W-1:0] per);
			result_t r;
			int n_fire;
			int hit_at;
			int free_at;
			logic [SLOT_W-1:0] ix;
			n_fire = 0;
			hit_at = -1;
			free_at = -1;
			ix = idx[SLOT_W-1:0];
			if (m == MODE_TICK) begin
				if (paused)
					return;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (valid[i]) begin
						if (elapsed[i] != ELAPSED_MAX)
							elapsed[i] = elapsed[i] + 1'b1;
						if (elapsed[i] >= period[i]) begin
							elapsed[i] = '0;
							r.kind = KIND_FIRE;
							r.slot = SLOT_PORT_W'(i);
							r.fired_task = tasks[i];
							r.status = FIRE_STATUS;
							r.last = 1'b0;
							pending_results.push_back(r);
							n_fire++;
						end
					end
				end
				if (n_fire > 0)
					pending_results[pending_results.size() - 1].last = 1'b1;
			end else if (m == MODE_ADD) begin
				if (per == '0) begin
					post_status('0, tid, STAT_RANGE);
					return;
				end
				if (tid >= NUM_TASK_KINDS) begin
					post_status('0, tid, STAT_INDEX);
					return;
				end
				for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
					if (valid[i] && tasks[i] == tid)
						hit_at = i;
					if (!valid[i])
						free_at = i;
				end
				if (hit_at >= 0) begin
					period[hit_at] = per;
					elapsed[hit_at] = '0;
					post_status(SLOT_PORT_W'(hit_at), tid, STAT_UPDATED);
				end else if (free_at < 0) begin
					post_status('0, tid, STAT_FULL);
				end else begin
					valid[free_at] = 1'b1;
					tasks[free_at] = tid;
					period[free_at] = per;
					elapsed[free_at] = '0;
					post_status(SLOT_PORT_W'(free_at), tid, STAT_ADDED);
				end
			end else if (idx >= NUM_SLOTS) begin
				post_status(idx, '0, STAT_INDEX);
			end else if (m == MODE_REMOVE) begin
				post_status(idx, tasks[ix], STAT_REMOVED);
				valid[ix] = 1'b0;
				tasks[ix] = '0;
				period[ix] = '0;
				elapsed[ix] = '0;
			end else if (!valid[ix]) begin
				post_status(idx, '0, STAT_INDEX);
			end else if (per == '0) begin
				post_status(idx, tasks[ix], STAT_RANGE);
			end else begin
				period[ix] = per;
				elapsed[ix] = '0;
				post_status(idx, tasks[ix], STAT_SET);
			end
		endfunction

		function void compare_field(input string name, input int want, input int got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: expected none actual %h",
					$time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("slot", want.slot, got.slot);
			compare_field("fired_task", want.fired_task, got.fired_task);
			compare_field("status", want.status, got.status);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [MODE_W-1:0]      mode;
	logic [TASK_W-1:0]      task_id;
	logic [SLOT_PORT_W-1:0] slot_index;
	logic [PERIOD_W-1:0]    period_ticks;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_data;
	logic                   res_strobe;
	logic                   kind;
	logic [SLOT_PORT_W-1:0] slot;
	logic [TASK_W-1:0]      fired_task;
	logic [STATUS_W-1:0]    status;
	logic                   last;

	slot_table_tracker tracker;
	bit gaps_on;
	int cycle_count = 0;

	periodic_task_slot_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.task_id      (task_id),
		.slot_index   (slot_index),
		.period_ticks (period_ticks),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.res_strobe   (res_strobe),
		.kind         (kind),
		.slot         (slot),
		.fired_task   (fired_task),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && res_strobe)
			tracker.check_result({kind, slot, fired_task, status, last});
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("periodic_task_slot_scheduler: mismatch");
			$finish;
		end
	end

	// Hold the command until the transaction is taken, then maybe idle
	task automatic issue(input logic [MODE_W-1:0] m, input logic [TASK_W-1:0] t,
			input logic [SLOT_PORT_W-1:0] s, input logic [PERIOD_W-1:0] p);
		mode <= m;
		task_id <= t;
		slot_index <= s;
		period_ticks <= p;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.take_command(m, t, s, p);
		if (gaps_on && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
	endtask

	// Drain: wait for every expected result, then let a silent tick finish
	task automatic settle();
		if (start)
			start <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_pause(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tracker.paused = v;
	endtask

	task automatic mix(input int count);
		int pick;
		logic [MODE_W-1:0] m;
		logic [PERIOD_W-1:0] p;
		logic [SLOT_PORT_W-1:0] s;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			m = (pick < 45) ? MODE_TICK : (pick < 65) ? MODE_ADD :
				(pick < 80) ? MODE_REMOVE : MODE_SET;
			// mostly short periods so slots actually fire
			pick = $urandom_range(0, 99);
			p = (pick < 70) ? PERIOD_W'($urandom_range(1, 6)) :
				(pick < 80) ? '0 : PERIOD_W'($urandom());
			s = ($urandom_range(0, 99) < 75) ? SLOT_PORT_W'($urandom_range(0, NUM_SLOTS - 1)) :
				SLOT_PORT_W'($urandom_range(0, 15));
			issue(m, TASK_W'($urandom_range(0, 3)), s, p);
		end
	endtask

	initial begin
		tracker = new();
		gaps_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_TICK;
		task_id = '0;
		slot_index = '0;
		period_ticks = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		write_pause(1'b0);

		issue(MODE_TICK, 2'd0, 4'd0, 16'd0);
		issue(MODE_ADD, 2'd2, 4'd0, 16'd0);
		issue(MODE_ADD, 2'd0, 4'd0, 16'd3);
		issue(MODE_ADD, 2'd2, 4'd0, 16'd1);
		issue(MODE_ADD, 2'd3, 4'd15, 16'hFFFF);
		issue(MODE_TICK, 2'd3, 4'd15, 16'hFFFF);
		issue(MODE_TICK, 2'd0, 4'd0, 16'd0);
		issue(MODE_TICK, 2'd0, 4'd0, 16'd0);
		issue(MODE_SET, 2'd0, 4'd15, 16'd4);
		issue(MODE_SET, 2'd0, 4'd8, 16'd4);
		issue(MODE_SET, 2'd0, 4'd5, 16'd4);
		issue(MODE_SET, 2'd1, 4'd3, 16'd0);
		issue(MODE_SET, 2'd0, 4'd3, 16'd2);
		issue(MODE_SET, 2'd0, 4'd1, 16'd1);
		issue(MODE_REMOVE, 2'd3, 4'd6, 16'hFFFF);
		issue(MODE_REMOVE, 2'd0, 4'd9, 16'd0);
		issue(MODE_REMOVE, 2'd0, 4'd15, 16'd0);
		issue(MODE_REMOVE, 2'd0, 4'd1, 16'd0);
		issue(MODE_ADD, 2'd1, 4'd0, 16'd1);
		issue(MODE_TICK, 2'd0, 4'd0, 16'd0);
		issue(MODE_TICK, 2'd0, 4'd0, 16'd0);
		issue(MODE_TICK, 2'd0, 4'd0, 16'd0);
		issue(MODE_SET, 2'd0, 4'd7, 16'h8000);
		issue(MODE_ADD, 2'd3, 4'd0, 16'd6);
		settle();

		write_pause(1'b1);
		mix(60);
		settle();

		write_pause(1'b0);
		gaps_on = 1'b0;
		mix(120);
		gaps_on = 1'b1;
		mix(150);
		settle();

		write_pause(1'b1);
		mix(20);
		settle();

		write_pause(1'b0);
		mix(50);
		settle();

		if (tracker.errors == 0)
			$display("periodic_task_slot_scheduler: match");
		else
			$display("periodic_task_slot_scheduler: mismatch");
		$finish;
	end

endmodule
